// ===== hdl/mkde_pkg.sv =====
// Shared types and constants for the multi-key debounce event block.
// No dependencies.
package mkde_pkg;

   // Per-key press counter
   typedef logic [3:0] count_type;

   localparam count_type COUNT_MAX        = 4'd15;
   localparam count_type PRESS_MIN_RESET  = 4'd4;

endpackage

// ===== hdl/multi_key_debounce_event.sv =====
// Multi-key debounce with press events: one poll of the key pins per transfer.
// An input transfer is captured in the input register and, once the result register is free,
// its result is written to the result register that drives rsp_valid. Throughput: one poll
// per cycle while rsp_stall does not hold the result; the input register feeds the scan logic,
// which updates the counters and writes the result register in the same cycle. Reset
// (synchronous, active high) clears counters and flags, empties both registers and sets press_minimum to 4.
module multi_key_debounce_event
   import mkde_pkg::*;
#(
   parameter int NUM_KEYS = 5,
   localparam int IDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   // poll input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [NUM_KEYS-1:0] req_key_pins_n,
   // result
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_event_valid,
   output logic [IDX_W-1:0]    rsp_key_index,
   // configuration
   input  logic                csr_wr_en,
   input  count_type           csr_wr_data
);

   logic                      in_valid_ff, in_valid_in;
   logic [NUM_KEYS-1:0]       in_pins_ff;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_event_ff;
   logic [IDX_W-1:0]          out_index_ff;
   count_type                 press_min_ff;
   count_type [NUM_KEYS-1:0]  count_ff;
   logic [NUM_KEYS-1:0]       flags_ff;

   count_type [NUM_KEYS-1:0]  count_in;
   logic [NUM_KEYS-1:0]       flags_in;
   logic                      fire;
   logic [IDX_W-1:0]          fire_index;
   logic                      advance;
   logic                      req_xfer;

   // Result register is free when empty or its transfer completes
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   mkde_scan #(
      .NUM_KEYS (NUM_KEYS),
      .IDX_W    (IDX_W)
   ) u_scan (
      .pins_n     (in_pins_ff),
      .press_min  (press_min_ff),
      .count_cur  (count_ff),
      .flags_cur  (flags_ff),
      .count_nxt  (count_in),
      .flags_nxt  (flags_in),
      .fire       (fire),
      .fire_index (fire_index)
   );

   // Control and key state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         press_min_ff <= PRESS_MIN_RESET;
         count_ff     <= '0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            press_min_ff <= csr_wr_data;
         end
         if (advance) begin
            count_ff <= count_in;
            flags_ff <= flags_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_pins_ff <= req_key_pins_n;
      end
      if (advance) begin
         out_event_ff <= fire;
         out_index_ff <= fire_index;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_valid = out_event_ff;
   assign rsp_key_index   = out_index_ff;

endmodule

// ===== hdl/mkde_scan.sv =====
// Priority key scan: one poll of all keys, next counter and flag state, fired key.
// Depends on mkde_pkg.
module mkde_scan
   import mkde_pkg::*;
#(
   parameter int NUM_KEYS = 5,
   parameter int IDX_W    = 3
) (
   input  logic [NUM_KEYS-1:0]            pins_n,
   input  count_type                      press_min,
   input  count_type [NUM_KEYS-1:0]       count_cur,
   input  logic [NUM_KEYS-1:0]            flags_cur,
   output count_type [NUM_KEYS-1:0]       count_nxt,
   output logic [NUM_KEYS-1:0]            flags_nxt,
   output logic                           fire,
   output logic [IDX_W-1:0]               fire_index
);

   // Scan from key 0 upward; once a key fires, higher keys hold their state
   always_comb begin
      logic      found;
      logic      pressed;
      count_type inc;
      found      = 1'b0;
      fire_index = '0;
      count_nxt  = count_cur;
      flags_nxt  = flags_cur;
      for (int i = 0; i < NUM_KEYS; i++) begin
         pressed = ~pins_n[i];
         inc     = (count_cur[i] == COUNT_MAX) ? count_cur[i] : count_cur[i] + 4'd1;
         if (!found) begin
            if (pressed) begin
               count_nxt[i] = inc;
               if ((inc >= press_min) && !flags_cur[i]) begin
                  flags_nxt[i] = 1'b1;
                  count_nxt[i] = '0;
                  found        = 1'b1;
                  fire_index   = IDX_W'(i);
               end
            end else begin
               // released: clear counter and reported flag
               count_nxt[i] = '0;
               flags_nxt[i] = 1'b0;
            end
         end
      end
      fire = found;
   end

endmodule

// ===== hdl/mkde_checker.sv =====
// Port-level checks for multi_key_debounce_event, attached by bind.
// Uses no package types; all of its ports are plain logic.
module mkde_checker #(
   parameter int NUM_KEYS = 5,
   parameter int IDX_W    = 3
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_event_valid,
   input logic [IDX_W-1:0] rsp_key_index
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_valid)
                                  && $stable(rsp_key_index))
      else $error("result changed while stalled");

   // A result without an event carries index zero
   a_no_event_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_key_index == '0)
      else $error("key index non-zero without event");

   // Fired key index is a real key
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_valid |-> int'(rsp_key_index) < NUM_KEYS)
      else $error("key index out of range");

   // Nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multi_key_debounce_event mkde_checker #(
   .NUM_KEYS (NUM_KEYS),
   .IDX_W    (IDX_W)
) u_mkde_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_valid (rsp_event_valid),
   .rsp_key_index   (rsp_key_index)
);
